[sv/rhls_pkg.sv]
// ----------------------------------------------------------------------------
// rhls_pkg: shared types and constants for the RGB to HLS converter
// Holds channel and result widths, hue sector codes and the records that
// travel along the divider chain.
// ----------------------------------------------------------------------------
`default_nettype none

package rhls_pkg;

  localparam int CHAN_W    = 8;
  localparam int HUE_W     = 9;
  localparam int QUO_W     = 8;
  localparam int REM_W     = 16;
  localparam int DIV_STEPS = QUO_W;

  localparam logic [HUE_W-1:0] HUE_RED   = 9'd0;
  localparam logic [HUE_W-1:0] HUE_GREEN = 9'd120;
  localparam logic [HUE_W-1:0] HUE_BLUE  = 9'd240;
  localparam logic [HUE_W:0]   HUE_WRAP  = 10'd360;

  typedef enum logic [1:0] {
    SECT_RED   = 2'd0,
    SECT_GREEN = 2'd1,
    SECT_BLUE  = 2'd2
  } sector_t;

  // One lane of the restoring divider: partial remainder, shifted divisor
  // and the quotient bits found so far.
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [REM_W-1:0] dsh;
    logic [QUO_W-1:0] quo;
  } div_lane_t;

  // Data that rides along with the division unchanged.
  typedef struct packed {
    logic [CHAN_W-1:0] light;
    logic              achrom;
    sector_t           sector;
    logic              neg;
  } side_t;

endpackage

`default_nettype wire

[sv/rhls_front.sv]
// ----------------------------------------------------------------------------
// rhls_front: channel analysis
// Finds the largest and smallest channel, the hue sector and the signed
// difference, and forms the numerators and divisors of both divisions.
// ----------------------------------------------------------------------------
`default_nettype none

module rhls_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic [rhls_pkg::CHAN_W-1:0] red_in,
  input  wire logic [rhls_pkg::CHAN_W-1:0] green_in,
  input  wire logic [rhls_pkg::CHAN_W-1:0] blue_in,
  output logic                             out_valid,
  output rhls_pkg::div_lane_t              sat_lane,
  output rhls_pkg::div_lane_t              hue_lane,
  output rhls_pkg::side_t                  side
);

  rhls_pkg::sector_t         sector;
  logic [rhls_pkg::CHAN_W-1:0] mx, mn, d, den, den_eff, d_eff, op_a, op_b, mag;
  logic [rhls_pkg::CHAN_W:0]   sum, far;
  logic                        neg, achrom;
  rhls_pkg::div_lane_t         sat_lane_next, hue_lane_next;
  rhls_pkg::side_t             side_next;

  always_comb begin
    // Ties go to red first, then green.
    if (red_in >= green_in && red_in >= blue_in) begin
      sector = rhls_pkg::SECT_RED;
    end else if (green_in >= blue_in) begin
      sector = rhls_pkg::SECT_GREEN;
    end else begin
      sector = rhls_pkg::SECT_BLUE;
    end

    mn = red_in;
    if (green_in < mn) mn = green_in;
    if (blue_in < mn) mn = blue_in;

    unique case (sector)
      rhls_pkg::SECT_RED: begin
        mx = red_in;   op_a = green_in; op_b = blue_in;
      end
      rhls_pkg::SECT_GREEN: begin
        mx = green_in; op_a = blue_in;  op_b = red_in;
      end
      default: begin
        mx = blue_in;  op_a = red_in;   op_b = green_in;
      end
    endcase

    d      = mx - mn;
    sum    = {1'b0, mx} + {1'b0, mn};
    far    = 9'd510 - sum;
    den    = (sum <= 9'd255) ? sum[rhls_pkg::CHAN_W-1:0] : far[rhls_pkg::CHAN_W-1:0];
    achrom = (d == '0);
    neg    = (op_b > op_a);
    mag    = neg ? (op_b - op_a) : (op_a - op_b);

    // Keep the divisors nonzero for gray pixels; the results are overridden.
    den_eff = achrom ? 8'd1 : den;
    d_eff   = achrom ? 8'd1 : d;

    sat_lane_next.rem = {d, 8'h00} - {8'h00, d};
    sat_lane_next.dsh = {1'b0, den_eff, 7'b0};
    sat_lane_next.quo = '0;
    hue_lane_next.rem = {2'b00, mag, 6'b0} - {6'b0, mag, 2'b00};
    hue_lane_next.dsh = {1'b0, d_eff, 7'b0};
    hue_lane_next.quo = '0;

    side_next.light  = sum[rhls_pkg::CHAN_W:1];
    side_next.achrom = achrom;
    side_next.sector = sector;
    side_next.neg    = neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    sat_lane <= sat_lane_next;
    hue_lane <= hue_lane_next;
    side     <= side_next;
  end

endmodule

`default_nettype wire

[sv/rhls_div_cell.sv]
// ----------------------------------------------------------------------------
// rhls_div_cell: one step of the pipelined divider chain
// Settles one quotient bit of each lane and hands the shifted divisor and
// the rest of the record to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rhls_div_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire rhls_pkg::div_lane_t sat_in,
  input  wire rhls_pkg::div_lane_t hue_in,
  input  wire rhls_pkg::side_t     side_in,
  output logic                     out_valid,
  output rhls_pkg::div_lane_t      sat_out,
  output rhls_pkg::div_lane_t      hue_out,
  output rhls_pkg::side_t          side_out
);

  rhls_pkg::div_lane_t sat_next, hue_next;

  function automatic rhls_pkg::div_lane_t div_step(input rhls_pkg::div_lane_t l);
    rhls_pkg::div_lane_t r;
    logic                ge;
    ge    = (l.rem >= l.dsh);
    r.rem = ge ? (l.rem - l.dsh) : l.rem;
    r.dsh = {1'b0, l.dsh[rhls_pkg::REM_W-1:1]};
    r.quo = {l.quo[rhls_pkg::QUO_W-2:0], ge};
    return r;
  endfunction

  always_comb begin
    sat_next = div_step(sat_in);
    hue_next = div_step(hue_in);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    sat_out  <= sat_next;
    hue_out  <= hue_next;
    side_out <= side_in;
  end

endmodule

`default_nettype wire

[sv/rhls_back.sv]
// ----------------------------------------------------------------------------
// rhls_back: result assembly
// Adds the signed hue quotient to the sector offset with floor rounding and wrap,
// handles gray pixels and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rhls_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire rhls_pkg::div_lane_t         sat_lane,
  input  wire rhls_pkg::div_lane_t         hue_lane,
  input  wire rhls_pkg::side_t             side,
  output logic                             done,
  output logic [rhls_pkg::HUE_W-1:0]       hue_deg,
  output logic [rhls_pkg::CHAN_W-1:0]      lightness,
  output logic [rhls_pkg::CHAN_W-1:0]      saturation,
  output logic                             achromatic
);

  logic [rhls_pkg::HUE_W-1:0] offset, q_up, hue_next;
  logic [rhls_pkg::HUE_W:0]   wrapped;

  always_comb begin
    unique case (side.sector)
      rhls_pkg::SECT_RED:   offset = rhls_pkg::HUE_RED;
      rhls_pkg::SECT_GREEN: offset = rhls_pkg::HUE_GREEN;
      default:              offset = rhls_pkg::HUE_BLUE;
    endcase

    // A negative quotient rounds toward minus infinity: bump the magnitude
    // when the division left a remainder.
    q_up    = {1'b0, hue_lane.quo} + {{(rhls_pkg::HUE_W-1){1'b0}}, (hue_lane.rem != '0)};
    wrapped = {1'b0, offset} + rhls_pkg::HUE_WRAP - {1'b0, q_up};

    if (side.achrom) begin
      hue_next = '0;
    end else if (!side.neg) begin
      hue_next = offset + {1'b0, hue_lane.quo};
    end else if (q_up > offset) begin
      hue_next = wrapped[rhls_pkg::HUE_W-1:0];
    end else begin
      hue_next = offset - q_up;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    hue_deg    <= hue_next;
    lightness  <= side.light;
    saturation <= side.achrom ? '0 : sat_lane.quo;
    achromatic <= side.achrom;
  end

endmodule

`default_nettype wire

[sv/rgb_to_hls_pixel.sv]
// A pixel passes the channel analysis register, eight divider cells and one
// output register on its way from the start transfer to the done strobe.
// One pixel per clock; each divider cell settles one quotient bit.
// busy stays low, so a new pixel can be started in every cycle.
// Reset (rst, synchronous, active high) clears the valid flags along the chain.
// ----------------------------------------------------------------------------
// rgb_to_hls_pixel: RGB to hue, lightness and saturation converter
// Converts one 8-bit RGB pixel per clock into hue in degrees, lightness,
// saturation and a gray flag, using a chain of restoring divider cells.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hls_pixel (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [rhls_pkg::CHAN_W-1:0] red_in,
  input  wire logic [rhls_pkg::CHAN_W-1:0] green_in,
  input  wire logic [rhls_pkg::CHAN_W-1:0] blue_in,
  output logic                             done,
  output logic [rhls_pkg::HUE_W-1:0]       hue_deg,
  output logic [rhls_pkg::CHAN_W-1:0]      lightness,
  output logic [rhls_pkg::CHAN_W-1:0]      saturation,
  output logic                             achromatic
);

  // The pipeline never stalls because the receiver always takes the result,
  // so every start is a transfer.
  assign busy = 1'b0;

  // Position 0 is the output of the front stage; position k+1 is the output of
  // divider cell k.
  logic                valid_chain [rhls_pkg::DIV_STEPS+1];
  rhls_pkg::div_lane_t sat_chain   [rhls_pkg::DIV_STEPS+1];
  rhls_pkg::div_lane_t hue_chain   [rhls_pkg::DIV_STEPS+1];
  rhls_pkg::side_t     side_chain  [rhls_pkg::DIV_STEPS+1];

  // The front stage finds max, min and the hue sector, and sets up the two
  // divisions: saturation is 255*delta over the lightness-dependent divisor,
  // hue is 60*|diff| over delta.
  rhls_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start & ~busy),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .out_valid (valid_chain[0]),
    .sat_lane  (sat_chain[0]),
    .hue_lane  (hue_chain[0]),
    .side      (side_chain[0])
  );

  // Both quotients fit in eight bits, since delta never exceeds the saturation
  // divisor and |diff| never exceeds delta, so eight cells finish both divisions.
  for (genvar k = 0; k < rhls_pkg::DIV_STEPS; k++) begin : g_cell
    rhls_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid_chain[k]),
      .sat_in    (sat_chain[k]),
      .hue_in    (hue_chain[k]),
      .side_in   (side_chain[k]),
      .out_valid (valid_chain[k+1]),
      .sat_out   (sat_chain[k+1]),
      .hue_out   (hue_chain[k+1]),
      .side_out  (side_chain[k+1])
    );
  end

  // The back stage applies the sector offset, floor rounding and the wrap
  // into 0..359, and forces gray pixels to hue 0 and saturation 0.
  rhls_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (valid_chain[rhls_pkg::DIV_STEPS]),
    .sat_lane   (sat_chain[rhls_pkg::DIV_STEPS]),
    .hue_lane   (hue_chain[rhls_pkg::DIV_STEPS]),
    .side       (side_chain[rhls_pkg::DIV_STEPS]),
    .done       (done),
    .hue_deg    (hue_deg),
    .lightness  (lightness),
    .saturation (saturation),
    .achromatic (achromatic)
  );

endmodule

`default_nettype wire

[tb/rgb_to_hls_pixel_test.sv]
// ----------------------------------------------------------------------------
// rgb_to_hls_pixel_test: self-checking bench for the RGB to HLS converter
// Sends a directed set of corner pixels followed by random pixels through the
// converter, predicts hue, lightness, saturation and the gray flag for each
// accepted pixel, and compares every done strobe against the oldest
// prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hls_pixel_test;

  localparam int RANDOM_PIXELS = 1700;
  localparam int QUIET_TAIL    = 200;  // last transfers are sent with no gaps
  localparam int SETTLE_CYCLES = 12;   // pipeline is 10 deep
  localparam int RUN_LIMIT     = 2000000;

  typedef logic [rhls_pkg::CHAN_W-1:0] chan_t;
  typedef logic [rhls_pkg::HUE_W-1:0]  hue_t;

  // One pixel waiting to be sent. When wait_drain is set, the driver holds
  // the pixel back until every result already in flight has come out.
  typedef struct {
    chan_t red;
    chan_t green;
    chan_t blue;
    bit    wait_drain;
  } pixel_t;

  // Predicted converter output for one pixel.
  typedef struct packed {
    hue_t  hue;
    chan_t light;
    chan_t sat;
    logic  gray;
  } hls_t;

  logic  clk;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  chan_t red_in = '0;
  chan_t green_in = '0;
  chan_t blue_in = '0;
  logic  busy;
  logic  done;
  hue_t  hue_deg;
  chan_t lightness;
  chan_t saturation;
  logic  achromatic;

  pixel_t pending_pixels[$];
  hls_t   hls_expected[$];
  bit     start_taken = 1'b0;  // the pixel on the inputs was taken at the last edge
  int     idle_left = 0;
  int     pixels_sent = 0;
  int     total_pixels = 0;
  int     fail_count = 0;

  rgb_to_hls_pixel u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .done      (done),
    .hue_deg   (hue_deg),
    .lightness (lightness),
    .saturation(saturation),
    .achromatic(achromatic)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Integer HLS conversion. Lightness is the mean of the extreme channels
  // rounded down; saturation is 255 times the spread over the sum, or over its
  // mirror around 510 when the sum exceeds 255; hue is the sector
  // base plus sixty times the signed difference over the spread, with the
  // quotient rounded toward minus infinity and negative hues folded up by 360.
  function automatic hls_t hls_of(chan_t r, chan_t g, chan_t b);
    hls_t              res;
    int                hi, lo, spread, sum, diff, num, quo, hue;
    rhls_pkg::sector_t sect;
    hi = int'(r);
    if (g > hi) hi = int'(g);
    if (b > hi) hi = int'(b);
    lo = int'(r);
    if (g < lo) lo = int'(g);
    if (b < lo) lo = int'(b);
    sum = hi + lo;
    res.light = sum[rhls_pkg::CHAN_W:1];
    if (hi == lo) begin
      res.hue  = '0;
      res.sat  = '0;
      res.gray = 1'b1;
      return res;
    end
    spread = hi - lo;
    if (sum <= 255) res.sat = chan_t'((255 * spread) / sum);
    else res.sat = chan_t'((255 * spread) / (510 - sum));
    // Ties for the largest channel go to red, then to green.
    if (int'(r) == hi) begin
      sect = rhls_pkg::SECT_RED;
      diff = int'(g) - int'(b);
    end else if (int'(g) == hi) begin
      sect = rhls_pkg::SECT_GREEN;
      diff = int'(b) - int'(r);
    end else begin
      sect = rhls_pkg::SECT_BLUE;
      diff = int'(r) - int'(g);
    end
    num = 60 * diff;
    if (num >= 0) quo = num / spread;
    else quo = -((-num + spread - 1) / spread);
    case (sect)
      rhls_pkg::SECT_RED:   hue = int'(rhls_pkg::HUE_RED) + quo;
      rhls_pkg::SECT_GREEN: hue = int'(rhls_pkg::HUE_GREEN) + quo;
      default:              hue = int'(rhls_pkg::HUE_BLUE) + quo;
    endcase
    if (hue < 0) hue += int'(rhls_pkg::HUE_WRAP);
    res.hue  = hue[rhls_pkg::HUE_W-1:0];
    res.gray = 1'b0;
    return res;
  endfunction

  task automatic queue_pixel(int r, int g, int b, bit wait_drain);
    pixel_t p;
    p.red        = r[rhls_pkg::CHAN_W-1:0];
    p.green      = g[rhls_pkg::CHAN_W-1:0];
    p.blue       = b[rhls_pkg::CHAN_W-1:0];
    p.wait_drain = wait_drain;
    pending_pixels.push_back(p);
  endtask

  // Driver. Inputs change on the falling edge. A pixel stays on the inputs
  // until the rising edge that takes it; between transfers it inserts random
  // idle gaps, but only in alternating stretches of 64 pixels and never in the
  // tail of the run. Idle cycles carry random noise on the channel inputs,
  // which the converter must ignore while start is low.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !start_taken) begin
      // Still waiting for the current transfer.
    end else if (idle_left > 0) begin
      idle_left <= idle_left - 1;
      start     <= 1'b0;
      red_in    <= chan_t'($urandom);
      green_in  <= chan_t'($urandom);
      blue_in   <= chan_t'($urandom);
    end else if (pending_pixels.size() == 0) begin
      start <= 1'b0;
    end else if (pending_pixels[0].wait_drain && hls_expected.size() != 0) begin
      start <= 1'b0;
    end else if (pixels_sent < total_pixels - QUIET_TAIL && (pixels_sent % 128) < 64
                 && $urandom_range(0, 7) == 0) begin
      idle_left <= $urandom_range(1, 11) - 1;
      start     <= 1'b0;
      red_in    <= chan_t'($urandom);
      green_in  <= chan_t'($urandom);
      blue_in   <= chan_t'($urandom);
    end else begin
      red_in      <= pending_pixels[0].red;
      green_in    <= pending_pixels[0].green;
      blue_in     <= pending_pixels[0].blue;
      start       <= 1'b1;
      pixels_sent <= pixels_sent + 1;
      void'(pending_pixels.pop_front());
    end
  end

  // Monitor. On each rising edge it first checks a done strobe against the
  // oldest prediction, then records a new prediction if a transfer happens
  // at this edge. The receiver side has no back-pressure, so every strobe
  // must line up with a pending prediction.
  always @(posedge clk) begin : check_results
    hls_t want;
    if (!rst && done) begin
      if (hls_expected.size() == 0) begin
        $error("result with no pixel outstanding: hue_deg %0d lightness %0d",
               hue_deg, lightness);
        fail_count++;
      end else begin
        want = hls_expected.pop_front();
        if (hue_deg !== want.hue) begin
          $error("hue_deg: expected %0d, actual %0d", want.hue, hue_deg);
          fail_count++;
        end
        if (lightness !== want.light) begin
          $error("lightness: expected %0d, actual %0d", want.light, lightness);
          fail_count++;
        end
        if (saturation !== want.sat) begin
          $error("saturation: expected %0d, actual %0d", want.sat, saturation);
          fail_count++;
        end
        if (achromatic !== want.gray) begin
          $error("achromatic: expected %0d, actual %0d", want.gray, achromatic);
          fail_count++;
        end
      end
    end
    if (!rst && start && !busy) begin
      hls_expected.push_back(hls_of(red_in, green_in, blue_in));
      start_taken <= 1'b1;
    end else begin
      start_taken <= 1'b0;
    end
  end

  // Stimulus and end of run.
  initial begin : run_test
    int kind, v, w;
    // Directed corners: black, white and mid gray; the primaries and
    // secondaries, which exercise the tie rules; a hue just below zero that
    // has to wrap; the smallest nonzero spreads; sums on both sides of the
    // saturation crossover at 255.
    queue_pixel(0, 0, 0, 1'b0);
    queue_pixel(255, 255, 255, 1'b0);
    queue_pixel(128, 128, 128, 1'b0);
    queue_pixel(255, 0, 0, 1'b0);
    queue_pixel(0, 255, 0, 1'b0);
    queue_pixel(0, 0, 255, 1'b0);
    queue_pixel(255, 255, 0, 1'b0);
    queue_pixel(0, 255, 255, 1'b0);
    queue_pixel(255, 0, 255, 1'b0);
    queue_pixel(255, 0, 1, 1'b0);
    queue_pixel(1, 0, 0, 1'b0);
    queue_pixel(0, 1, 0, 1'b0);
    queue_pixel(0, 0, 1, 1'b0);
    queue_pixel(128, 127, 127, 1'b0);
    queue_pixel(128, 128, 127, 1'b0);
    queue_pixel(129, 128, 128, 1'b0);
    queue_pixel(255, 254, 254, 1'b0);
    queue_pixel(254, 255, 255, 1'b0);
    queue_pixel(170, 85, 0, 1'b0);
    queue_pixel(0, 85, 170, 1'b0);
    queue_pixel(200, 100, 50, 1'b0);
    queue_pixel(10, 20, 30, 1'b0);
    queue_pixel(30, 10, 20, 1'b0);
    queue_pixel(255, 1, 0, 1'b0);

    // Random part. Most pixels are uniform; the rest are biased toward gray
    // pixels, two-way ties and channel values at the edges of the range.
    // The first random pixel and a few scattered ones wait for the pipeline
    // to drain before they go in.
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      kind = $urandom_range(0, 9);
      v    = $urandom_range(0, 255);
      w    = $urandom_range(0, 255);
      case (kind)
        0: queue_pixel(v, v, v, i == 0);
        1: begin
          case ($urandom_range(0, 2))
            0:       queue_pixel(v, v, w, i == 0);
            1:       queue_pixel(v, w, v, i == 0);
            default: queue_pixel(w, v, v, i == 0);
          endcase
        end
        2: queue_pixel($urandom_range(0, 1) ? $urandom_range(254, 255) : $urandom_range(0, 1),
                       $urandom_range(0, 1) ? $urandom_range(254, 255) : $urandom_range(0, 1),
                       $urandom_range(0, 1) ? $urandom_range(254, 255) : $urandom_range(0, 1),
                       i == 0);
        default: queue_pixel(v, w, $urandom_range(0, 255),
                             i == 0 || $urandom_range(0, 199) == 0);
      endcase
    end
    total_pixels = pending_pixels.size();

    // Reset is held from time zero and released on a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait until the last pixel has been taken, then until every prediction
    // has been matched, and let the pipeline run a little longer so that a
    // stray strobe would still be caught.
    while (pending_pixels.size() != 0 || start) @(posedge clk);
    while (hls_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #RUN_LIMIT;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
